@@ hw/rtl/skset_pkg.sv @@
// skset_pkg: shared sizes, command and status codes, and cell control types
// for the sorted key set. No dependencies.
`default_nettype none

package skset_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEARCH = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_MISS = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // broadcast to every cell for the beat being taken
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_ctrl_t;

    // per-cell compare results
    typedef struct packed {
        logic lt;
        logic eq;
        logic first;
    } cell_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/skset_cell.sv @@
// skset_cell: one slot of the sorted chain, holding one key, comparing it
// with the incoming key and shifting to or from its neighbours. Uses skset_pkg.
`default_nettype none

module skset_cell
    import skset_pkg::*;
(
    input  wire logic              aclk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic              occupied,
    input  wire logic [KEY_W-1:0]  key_in,
    input  wire logic              lt_left,
    input  wire logic [KEY_W-1:0]  key_left,
    input  wire logic [KEY_W-1:0]  key_right,
    output cell_flags_t            flags,
    output logic [KEY_W-1:0]       key_out
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    always_comb begin
        flags.lt    = occupied && ($signed(key_reg) < $signed(key_in));
        flags.eq    = occupied && (key_reg == key_in);
        // first slot not below the key: the insertion point
        flags.first = !flags.lt && lt_left;
    end

    always_comb begin
        key_next = key_reg;
        if (ctrl.shift_up && !flags.lt) begin
            key_next = flags.first ? key_in : key_left;
        end else if (ctrl.shift_down && !flags.lt) begin
            key_next = key_right;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_out = key_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_key_set.sv @@
// sorted_key_set: top level; a chain of skset_cell slots with the count,
// command decode and result register. Uses skset_pkg and skset_cell.
//
//   port group   dir  tdata fields (low bit up)              tuser/tlast
//   s_axis       in   command[1:0] key[33:2] pad[39:34]      none
//   m_axis       out  status[1:0] position[5:2] count[10:6]  none
//
// one beat per cycle unless the result register stalls: every cell compares
// and shifts in the same cycle, so the compare across the chain plus the shift
// select sets the clock path. result appears in the cycle after the beat is taken,
// from the output register. reset clears the count and the output valid and
// holds s_tready low; the keys are not cleared.
// a stalled result register still takes a new beat when m_tready is high.
`default_nettype none

module sorted_key_set
    import skset_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // command[1:0], key[33:2]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata    // status[1:0], position[5:2], count[10:6]
);

    logic                 accept;
    cmd_t                 cmd;
    logic [KEY_W-1:0]     key;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic [M_DATA_W-1:0]  m_tdata_next;

    cell_ctrl_t           ctrl;
    cell_flags_t          flags    [CAPACITY];
    logic [KEY_W-1:0]     keys     [CAPACITY];
    logic [CAPACITY-1:0]  eq_vec;
    logic [CAPACITY-1:0]  first_vec;

    logic                 found;
    logic                 full;
    logic [IDX_W-1:0]     lb;
    status_t              status;
    logic                 report_pos;
    logic [31:0]          pos_wide;
    logic [31:0]          count_wide;

    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tdata[CMD_W-1:0]);
    assign key      = s_tdata[CMD_W +: KEY_W];

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic             occ;
        logic             lt_l;
        logic [KEY_W-1:0] key_l;
        logic [KEY_W-1:0] key_r;

        assign occ = CNT_W'(g) < count_reg;

        if (g == 0) begin : g_head
            assign lt_l  = 1'b1;
            assign key_l = key;
        end else begin : g_body
            assign lt_l  = flags[g-1].lt;
            assign key_l = keys[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign key_r = keys[g];
        end else begin : g_mid
            assign key_r = keys[g+1];
        end

        skset_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (occ),
            .key_in    (key),
            .lt_left   (lt_l),
            .key_left  (key_l),
            .key_right (key_r),
            .flags     (flags[g]),
            .key_out   (keys[g])
        );

        assign eq_vec[g]    = flags[g].eq;
        assign first_vec[g] = flags[g].first;
    end

    // insertion point as an index, from the one-hot boundary
    always_comb begin
        lb = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_vec[i]) begin
                lb = lb | IDX_W'(i);
            end
        end
    end

    assign found = |eq_vec;
    assign full  = count_reg == CNT_W'(CAPACITY);

    always_comb begin
        status     = ST_OK;
        report_pos = 1'b0;
        ctrl       = '0;
        count_next = count_reg;
        unique case (cmd)
            CMD_SEARCH: begin
                status     = found ? ST_OK : ST_MISS;
                report_pos = found;
            end
            CMD_INSERT: begin
                if (found) begin
                    status = ST_DUP;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    report_pos    = 1'b1;
                    ctrl.shift_up = accept;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (found) begin
                    report_pos      = 1'b1;
                    ctrl.shift_down = accept;
                    count_next      = count_reg - CNT_W'(1);
                end else begin
                    status = ST_MISS;
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign pos_wide   = report_pos ? 32'(lb) : 32'd0;
    assign count_wide = 32'(count_next);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'd0, count_wide[COUNT_W-1:0], pos_wide[POS_W-1:0], status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    a_eq_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(eq_vec))
        else $error("key matched in more than one cell");

    a_first_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(first_vec))
        else $error("more than one insertion point");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.shift_up |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("count not advanced after insert");

    a_no_dual_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.shift_up && ctrl.shift_down))
        else $error("shift up and down together");

endmodule

`default_nettype wire
